[sv/fat_directory_entry_parser_defines.svh]
// Assertion macros for the bound checker file.
`ifndef FAT_DIRECTORY_ENTRY_PARSER_DEFINES_SVH
`define FAT_DIRECTORY_ENTRY_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FDEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FDEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fdep_pkg.sv]
`default_nettype none
package fdep_pkg;

  localparam int unsigned ENTRY_BYTES = 32;
  localparam int unsigned POS_W       = $clog2(ENTRY_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(ENTRY_BYTES - 1);

  // byte 0 markers
  localparam logic [7:0] FIRST_UNUSED  = 8'h00;
  localparam logic [7:0] FIRST_DELETED = 8'hE5;
  localparam logic [7:0] DOT_CHAR      = 8'h2E;

  // attribute bits
  localparam logic [7:0] ATTR_HIDE   = 8'h02;
  localparam logic [7:0] ATTR_SYSTEM = 8'h04;
  localparam logic [7:0] ATTR_LABEL  = 8'h08;
  localparam logic [7:0] ATTR_SUBDIR = 8'h10;

  localparam logic [11:0] YEAR_BASE = 12'd1980;

  typedef enum logic [2:0] {
    KIND_UNUSED  = 3'd0,
    KIND_DELETED = 3'd1,
    KIND_SKIPPED = 3'd2,
    KIND_FILE    = 3'd3,
    KIND_SUBDIR  = 3'd4,
    KIND_PARENT  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SEL_CREATED  = 2'd0,
    SEL_ACCESSED = 2'd1,
    SEL_MODIFIED = 2'd2,
    SEL_SPARE    = 2'd3
  } ts_sel_t;

  localparam ts_sel_t TS_SEL_RESET = SEL_MODIFIED;

  // one complete entry, as handed from front to back
  typedef struct packed {
    logic        clear;    // counts restart before this entry
    logic [7:0]  first;
    logic [7:0]  second;
    logic [7:0]  attr;
    logic [15:0] cluster;
    logic [31:0] size;
    logic [15:0] c_time;
    logic [15:0] c_date;
    logic [15:0] a_date;
    logic [15:0] m_time;
    logic [15:0] m_date;
  } entry_rec_t;

endpackage
`default_nettype wire

[sv/fdep_front.sv]
`default_nettype none
module fdep_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [7:0]         data_byte,
  input  wire logic               new_listing,
  output fdep_pkg::entry_rec_t    rec,
  output logic                    rec_push
);
  import fdep_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic             clr_r, clr_nxt;
  logic [7:0]       ent_r [0:ENTRY_BYTES-2];

  assign pos_eff  = new_listing ? '0 : pos_r;
  assign rec_push = take && (pos_eff == POS_LAST);

  always_comb begin
    pos_nxt = pos_r;
    clr_nxt = clr_r;
    if (take) begin
      if (pos_eff == POS_LAST) begin
        pos_nxt = '0;
        clr_nxt = 1'b0;
      end else begin
        pos_nxt = pos_eff + POS_W'(1);
        clr_nxt = clr_r | new_listing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      clr_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (pos_eff != POS_LAST)) begin
      ent_r[pos_eff] <= data_byte;
    end
  end

  // last byte comes straight from the input
  always_comb begin
    rec.clear   = clr_r | new_listing;
    rec.first   = ent_r[0];
    rec.second  = ent_r[1];
    rec.attr    = ent_r[11];
    rec.c_time  = {ent_r[15], ent_r[14]};
    rec.c_date  = {ent_r[17], ent_r[16]};
    rec.a_date  = {ent_r[19], ent_r[18]};
    rec.m_time  = {ent_r[23], ent_r[22]};
    rec.m_date  = {ent_r[25], ent_r[24]};
    rec.cluster = {ent_r[27], ent_r[26]};
    rec.size    = {data_byte, ent_r[30], ent_r[29], ent_r[28]};
  end

endmodule
`default_nettype wire

[sv/fdep_fifo.sv]
`default_nettype none
module fdep_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire fdep_pkg::entry_rec_t  wr_data,
  output logic                       full,
  input  wire logic                  pop,
  output fdep_pkg::entry_rec_t       rd_data,
  output logic                       empty
);
  import fdep_pkg::*;

  entry_rec_t  mem_r [0:1];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[sv/fdep_back.sv]
`default_nettype none
module fdep_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fdep_pkg::entry_rec_t  rec,
  input  wire logic                  rec_empty,
  output logic                       rec_pop,
  input  wire fdep_pkg::ts_sel_t     ts_sel,
  input  wire logic                  out_pop,
  output logic                       out_empty,
  output logic [2:0]                 entry_kind,
  output logic [7:0]                 attribute_bits,
  output logic [15:0]                start_cluster,
  output logic [31:0]                file_size,
  output logic [15:0]                files_counted,
  output logic [47:0]                bytes_counted,
  output logic [11:0]                stamp_year,
  output logic [3:0]                 stamp_month,
  output logic [4:0]                 stamp_day,
  output logic [4:0]                 stamp_hour,
  output logic [5:0]                 stamp_minute,
  output logic [5:0]                 stamp_second
);
  import fdep_pkg::*;

  logic        vld_r, vld_nxt;
  logic [15:0] cnt_r, cnt_nxt, cnt_base;
  logic [47:0] sum_r, sum_nxt, sum_base;
  logic [48:0] sum_wide;
  kind_t       kind;
  logic        listed;
  logic [15:0] date, tod;

  // result regs
  kind_t       kind_r;
  logic [7:0]  attr_r;
  logic [15:0] clus_r;
  logic [31:0] size_r;
  logic [11:0] year_r;
  logic [3:0]  mon_r;
  logic [4:0]  day_r, hour_r;
  logic [5:0]  min_r, sec_r;

  assign rec_pop = !rec_empty && (!vld_r || out_pop);

  always_comb begin
    priority if (rec.first == FIRST_UNUSED) begin
      kind = KIND_UNUSED;
    end else if (rec.first == FIRST_DELETED) begin
      kind = KIND_DELETED;
    end else if ((rec.attr & (ATTR_HIDE | ATTR_SYSTEM | ATTR_LABEL)) != '0) begin
      kind = KIND_SKIPPED;
    end else if ((rec.first == DOT_CHAR) || ((rec.attr & ATTR_SUBDIR) != '0)) begin
      kind = (rec.second == DOT_CHAR) ? KIND_PARENT : KIND_SUBDIR;
    end else begin
      kind = KIND_FILE;
    end
  end

  assign listed   = (kind == KIND_FILE) || (kind == KIND_SUBDIR) || (kind == KIND_PARENT);
  assign cnt_base = rec.clear ? '0 : cnt_r;
  assign sum_base = rec.clear ? '0 : sum_r;
  assign sum_wide = {1'b0, sum_base} + {17'd0, rec.size};

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (rec_pop) begin
      cnt_nxt = cnt_base;
      sum_nxt = sum_base;
      if (listed) begin
        cnt_nxt = (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
        sum_nxt = sum_wide[48] ? '1 : sum_wide[47:0];
      end
    end
    vld_nxt = rec_pop || (vld_r && !out_pop);
  end

  always_comb begin
    unique case (ts_sel)
      SEL_CREATED: begin
        date = rec.c_date;
        tod  = rec.c_time;
      end
      SEL_ACCESSED: begin
        date = rec.a_date;
        tod  = '0;
      end
      default: begin
        date = rec.m_date;
        tod  = rec.m_time;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      kind_r <= kind;
      attr_r <= rec.attr;
      clus_r <= rec.cluster;
      size_r <= rec.size;
      year_r <= YEAR_BASE + {5'd0, date[15:9]};
      mon_r  <= date[8:5];
      day_r  <= date[4:0];
      hour_r <= tod[15:11];
      min_r  <= tod[10:5];
      sec_r  <= {tod[4:0], 1'b0};
    end
  end

  assign out_empty      = !vld_r;
  assign entry_kind     = kind_r;
  assign attribute_bits = attr_r;
  assign start_cluster  = clus_r;
  assign file_size      = size_r;
  assign files_counted  = cnt_r;
  assign bytes_counted  = sum_r;
  assign stamp_year     = year_r;
  assign stamp_month    = mon_r;
  assign stamp_day      = day_r;
  assign stamp_hour     = hour_r;
  assign stamp_minute   = min_r;
  assign stamp_second   = sec_r;

endmodule
`default_nettype wire

[sv/fat_directory_entry_parser.sv]
// Channel  | Ports                                   | Beat taken when
// ---------+-----------------------------------------+-------------------------
// input    | in_push, in_full, in_data_byte,         | in_push  && !in_full
//          | in_new_listing                          |
// result   | out_empty, out_pop, out_entry_kind ...  | out_pop  && !out_empty
// config   | cfg_valid, cfg_ready,                   | cfg_valid && cfg_ready
//          | cfg_timestamp_select                    |
//
// One input byte per cycle while in_full is low; one result per 32 bytes, on the ports
// once the entry has passed the queue write and then the result register.
// Reset (rst_n low at a clock edge) clears position, counts, queue and the
// result valid flag; the stamp selector returns to "modified".
// in_full rises only when the two-entry queue is full, i.e. when two
// finished entries are held behind an unpopped result.
`default_nettype none
module fat_directory_entry_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input bytes
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_new_listing,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_timestamp_select,
  // results
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_entry_kind,
  output logic [7:0]       out_attribute_bits,
  output logic [15:0]      out_start_cluster,
  output logic [31:0]      out_file_size,
  output logic [15:0]      out_files_counted,
  output logic [47:0]      out_bytes_counted,
  output logic [11:0]      out_stamp_year,
  output logic [3:0]       out_stamp_month,
  output logic [4:0]       out_stamp_day,
  output logic [4:0]       out_stamp_hour,
  output logic [5:0]       out_stamp_minute,
  output logic [5:0]       out_stamp_second
);
  import fdep_pkg::*;

  // stamp selector register, always ready
  ts_sel_t    ts_sel_r, ts_sel_nxt;

  // front -> queue -> back
  entry_rec_t rec_in, rec_out;
  logic       rec_push, rec_pop, q_full, q_empty;
  logic       in_take;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_take   = in_push && !q_full;

  always_comb begin
    ts_sel_nxt = ts_sel_r;
    if (cfg_valid && cfg_ready) begin
      ts_sel_nxt = ts_sel_t'(cfg_timestamp_select);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_sel_r <= TS_SEL_RESET;
    end else begin
      ts_sel_r <= ts_sel_nxt;
    end
  end

  // front: tracks byte position and gathers the entry bytes
  fdep_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .data_byte   (in_data_byte),
    .new_listing (in_new_listing),
    .rec         (rec_in),
    .rec_push    (rec_push)
  );

  // two finished entries of slack between front and back
  fdep_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rec_push),
    .wr_data (rec_in),
    .full    (q_full),
    .pop     (rec_pop),
    .rd_data (rec_out),
    .empty   (q_empty)
  );

  // back: classifies, counts, decodes the stamp, holds the result
  fdep_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec            (rec_out),
    .rec_empty      (q_empty),
    .rec_pop        (rec_pop),
    .ts_sel         (ts_sel_r),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .entry_kind     (out_entry_kind),
    .attribute_bits (out_attribute_bits),
    .start_cluster  (out_start_cluster),
    .file_size      (out_file_size),
    .files_counted  (out_files_counted),
    .bytes_counted  (out_bytes_counted),
    .stamp_year     (out_stamp_year),
    .stamp_month    (out_stamp_month),
    .stamp_day      (out_stamp_day),
    .stamp_hour     (out_stamp_hour),
    .stamp_minute   (out_stamp_minute),
    .stamp_second   (out_stamp_second)
  );

endmodule
`default_nettype wire

[sv/fdep_checker.sv]
`default_nettype none
`include "fat_directory_entry_parser_defines.svh"
module fdep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_entry_kind,
  input wire logic [31:0] out_file_size,
  input wire logic [15:0] out_files_counted,
  input wire logic [47:0] out_bytes_counted,
  input wire logic [11:0] out_stamp_year
);

  `FDEP_ASSERT_NOW(a_kind_range, !out_empty, out_entry_kind <= 3'd5, "entry kind out of range")

  `FDEP_ASSERT_NOW(a_year_range, !out_empty, (out_stamp_year >= 12'd1980) && (out_stamp_year <= 12'd2107), "stamp year out of range")

  `FDEP_ASSERT_NOW(a_zero_count, !out_empty && (out_files_counted == 16'd0), out_bytes_counted == 48'd0, "bytes counted with no listed entry")

  `FDEP_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_file_size) && $stable(out_entry_kind), "result changed while stalled")

endmodule

bind fat_directory_entry_parser fdep_checker u_fdep_checker (.*);
`default_nettype wire

[tb/fdep_entry_checker.sv]
`timescale 1ns / 1ps
module fdep_entry_checker
  import fdep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_listing,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_timestamp_select,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_entry_kind,
  input  logic [7:0]  out_attribute_bits,
  input  logic [15:0] out_start_cluster,
  input  logic [31:0] out_file_size,
  input  logic [15:0] out_files_counted,
  input  logic [47:0] out_bytes_counted,
  input  logic [11:0] out_stamp_year,
  input  logic [3:0]  out_stamp_month,
  input  logic [4:0]  out_stamp_day,
  input  logic [4:0]  out_stamp_hour,
  input  logic [5:0]  out_stamp_minute,
  input  logic [5:0]  out_stamp_second,
  output int          mismatches,
  output int          awaited,
  output int          entries_seen
);

  typedef struct {
    kind_t       kind;
    logic [7:0]  attr;
    logic [15:0] cluster;
    logic [31:0] size;
    logic [15:0] files;
    logic [47:0] total;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } entry_summary_t;

  localparam logic [47:0] TOTAL_MAX = '1;

  logic [4:0]     fill_pos;
  logic [7:0]     entry_bytes [ENTRY_BYTES];
  logic [15:0]    listed_files;
  logic [47:0]    listed_total;
  ts_sel_t        stamp_sel;
  entry_summary_t summaries_due [$];

  initial begin
    mismatches   = 0;
    awaited      = 0;
    entries_seen = 0;
  end

  function automatic logic [15:0] le16(int unsigned at);
    return {entry_bytes[at + 1], entry_bytes[at]};
  endfunction

  // decodes the completed entry and advances the running counts
  function automatic entry_summary_t summarise_entry();
    entry_summary_t s;
    logic [15:0]    dt;
    logic [15:0]    tm;
    logic [7:0]     lead;
    lead      = entry_bytes[0];
    s.attr    = entry_bytes[11];
    s.cluster = le16(26);
    s.size    = {le16(30), le16(28)};
    if (lead == FIRST_UNUSED) begin
      s.kind = KIND_UNUSED;
    end else if (lead == FIRST_DELETED) begin
      s.kind = KIND_DELETED;
    end else if ((s.attr & (ATTR_HIDE | ATTR_SYSTEM | ATTR_LABEL)) != 8'd0) begin
      s.kind = KIND_SKIPPED;
    end else begin
      if (lead == DOT_CHAR || (s.attr & ATTR_SUBDIR) != 8'd0)
        s.kind = (entry_bytes[1] == DOT_CHAR) ? KIND_PARENT : KIND_SUBDIR;
      else
        s.kind = KIND_FILE;
      if (listed_files != 16'hFFFF)
        listed_files = listed_files + 16'd1;
      if (TOTAL_MAX - listed_total < {16'd0, s.size})
        listed_total = TOTAL_MAX;
      else
        listed_total = listed_total + {16'd0, s.size};
    end
    case (stamp_sel)
      SEL_CREATED: begin
        tm = le16(14);
        dt = le16(16);
      end
      SEL_ACCESSED: begin
        tm = 16'd0;
        dt = le16(18);
      end
      default: begin
        tm = le16(22);
        dt = le16(24);
      end
    endcase
    s.files  = listed_files;
    s.total  = listed_total;
    s.year   = {5'd0, dt[15:9]} + YEAR_BASE;
    s.month  = dt[8:5];
    s.day    = dt[4:0];
    s.hour   = tm[15:11];
    s.minute = tm[10:5];
    s.second = {tm[4:0], 1'b0};
    return s;
  endfunction

  task automatic check_field(input string label, input logic [47:0] got,
                             input logic [47:0] want);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: entry %0d %s expected 0x%0h got 0x%0h",
                 $time, entries_seen, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    entry_summary_t want;
    if (!rst_n) begin
      fill_pos     = '0;
      listed_files = '0;
      listed_total = '0;
      stamp_sel    = TS_SEL_RESET;
      summaries_due.delete();
    end else begin
      // result beat first: an entry finished at this edge cannot be on the port yet
      if (out_pop && !out_empty) begin
        if (summaries_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with no entry outstanding", $time);
          mismatches++;
        end else begin
          want = summaries_due.pop_front();
          check_field("entry_kind", out_entry_kind, want.kind);
          check_field("attribute_bits", out_attribute_bits, want.attr);
          check_field("start_cluster", out_start_cluster, want.cluster);
          check_field("file_size", out_file_size, want.size);
          check_field("files_counted", out_files_counted, want.files);
          check_field("bytes_counted", out_bytes_counted, want.total);
          check_field("stamp_year", out_stamp_year, want.year);
          check_field("stamp_month", out_stamp_month, want.month);
          check_field("stamp_day", out_stamp_day, want.day);
          check_field("stamp_hour", out_stamp_hour, want.hour);
          check_field("stamp_minute", out_stamp_minute, want.minute);
          check_field("stamp_second", out_stamp_second, want.second);
          entries_seen++;
        end
      end
      if (cfg_valid && cfg_ready)
        stamp_sel = ts_sel_t'(cfg_timestamp_select);
      if (in_push && !in_full) begin
        if (in_new_listing) begin
          fill_pos     = '0;
          listed_files = '0;
          listed_total = '0;
        end
        entry_bytes[fill_pos] = in_data_byte;
        if (fill_pos == POS_LAST) begin
          fill_pos = '0;
          summaries_due.push_back(summarise_entry());
        end else begin
          fill_pos = fill_pos + 5'd1;
        end
      end
    end
    awaited = summaries_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import fdep_pkg::*;

  // Random stimulus is split over three back-pressure phases of at least this many beats.
  localparam int RANDOM_BYTES_PER_PHASE = 330;
  // Result reaches the ports through the queue and the result register; leave some margin on top.
  localparam int DRAIN_CYCLES           = 8;
  // About 1650 beats plus idle gaps, stalls and drains; ample headroom.
  localparam int CYCLE_LIMIT            = 100_000;

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        in_push              = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte         = 8'd0;
  logic        in_new_listing       = 1'b0;
  logic        cfg_valid            = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_timestamp_select = 2'd0;
  logic        out_empty;
  logic        out_pop              = 1'b0;
  logic [2:0]  out_entry_kind;
  logic [7:0]  out_attribute_bits;
  logic [15:0] out_start_cluster;
  logic [31:0] out_file_size;
  logic [15:0] out_files_counted;
  logic [47:0] out_bytes_counted;
  logic [11:0] out_stamp_year;
  logic [3:0]  out_stamp_month;
  logic [4:0]  out_stamp_day;
  logic [4:0]  out_stamp_hour;
  logic [5:0]  out_stamp_minute;
  logic [5:0]  out_stamp_second;

  // from the checker
  int mismatches;
  int awaited;
  int entries_seen;

  // back-pressure knobs, percent of cycles spent idle
  int send_idle_pct = 26;
  int pop_idle_pct  = 72;

  int bytes_sent = 0;
  int cycles     = 0;

  // the 32-byte directory entry about to be sent
  logic [7:0] ent [ENTRY_BYTES];

  fat_directory_entry_parser dut (.*);

  fdep_entry_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit, %0d entries still outstanding", awaited);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: pop held low on a random share of cycles.
  always @(posedge clk)
    out_pop <= ($urandom_range(99) >= pop_idle_pct);

  // One input beat. Random idle cycles go in front, so gaps land on every byte
  // position of an entry. Called and left at a rising edge.
  task automatic send_byte(input logic [7:0] value, input logic realign);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= value;
    in_new_listing <= realign;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  // Whole entry; new_listing, if asked for, rides on byte 0 only.
  task automatic push_entry(input logic realign);
    for (int i = 0; i < ENTRY_BYTES; i++)
      send_byte(ent[i], realign && (i == 0));
  endtask

  // Sender holds off until every finished entry has come out.
  // Outstanding count is sampled on the falling edge, clear of the update.
  task automatic pause_sender();
    in_push <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  // Idle the whole block: drained, plus time for anything still in the pipe.
  task automatic settle();
    pause_sender();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stamp selector only changes with the block idle.
  task automatic write_stamp_select(input ts_sel_t sel);
    settle();
    cfg_valid            <= 1'b1;
    cfg_timestamp_select <= sel;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_entry(input logic [7:0] value);
    for (int i = 0; i < ENTRY_BYTES; i++)
      ent[i] = value;
  endtask

  // Random entry, biased towards the interesting markers so every kind turns up
  // often: unused/deleted/dot first bytes, dot second byte, clean attributes
  // (listed), subdirectory bit, and empty or full-scale sizes.
  task automatic randomise_entry();
    int pick;
    for (int i = 0; i < ENTRY_BYTES; i++)
      ent[i] = 8'($urandom);
    pick = $urandom_range(9);
    case (pick)
      0:       ent[0] = FIRST_UNUSED;
      1:       ent[0] = FIRST_DELETED;
      2, 3:    ent[0] = DOT_CHAR;
      default: ;
    endcase
    if ($urandom_range(9) < 3)
      ent[1] = DOT_CHAR;
    if ($urandom_range(1) == 1)
      ent[11] = ent[11] & ~(ATTR_HIDE | ATTR_SYSTEM | ATTR_LABEL);
    if ($urandom_range(3) == 0)
      ent[11] = ent[11] | ATTR_SUBDIR;
    pick = $urandom_range(9);
    if (pick < 2) begin
      for (int i = 28; i < 32; i++) ent[i] = 8'hFF;
    end else if (pick == 2) begin
      for (int i = 28; i < 32; i++) ent[i] = 8'h00;
    end
  endtask

  // Directed entry: random body, chosen first/second/attribute bytes.
  task automatic shaped_entry(input logic [7:0] lead, input logic [7:0] second,
                              input logic [7:0] attr, input logic realign);
    randomise_entry();
    ent[0]  = lead;
    ent[1]  = second;
    ent[11] = attr;
    push_entry(realign);
  endtask

  // Mostly well-formed entries; some broken ones (partial entry with random
  // new_listing, then a realigned entry) and the odd full drain.
  task automatic random_phase(input ts_sel_t sel, input int snd_idle, input int rcv_idle);
    int start;
    int pick;
    int cut;
    write_stamp_select(sel);
    send_idle_pct = snd_idle;
    pop_idle_pct  = rcv_idle;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES_PER_PHASE) begin
      pick = $urandom_range(99);
      randomise_entry();
      if (pick < 6) begin
        cut = $urandom_range(31, 1);
        for (int i = 0; i < cut; i++)
          send_byte(ent[i], 1'($urandom_range(1)));
        randomise_entry();
        push_entry(1'b1);
      end else if (pick < 9) begin
        pause_sender();
      end else begin
        push_entry(pick < 16);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed: first phase idling (sender 26 %, receiver 72 %) ----
    // all-zero entry: unused, every field at its floor, year 1980
    fill_entry(8'h00);
    push_entry(1'b0);
    // deleted entry with every field at its ceiling
    fill_entry(8'hFF);
    ent[0] = FIRST_DELETED;
    push_entry(1'b0);
    // listed file, full-scale size and stamp
    fill_entry(8'hFF);
    ent[0]  = 8'h41;
    ent[11] = 8'h20;
    push_entry(1'b0);
    // each skip attribute, and skip taking precedence over the subdirectory bit
    shaped_entry(8'h41, 8'h42, ATTR_HIDE, 1'b0);
    shaped_entry(8'h41, 8'h42, ATTR_SYSTEM, 1'b0);
    shaped_entry(8'h41, 8'h42, ATTR_LABEL, 1'b0);
    shaped_entry(8'h41, 8'h42, ATTR_HIDE | ATTR_SUBDIR, 1'b0);
    shaped_entry(DOT_CHAR, DOT_CHAR, ATTR_LABEL, 1'b0);
    // first-byte markers win over attributes
    shaped_entry(FIRST_DELETED, DOT_CHAR, ATTR_SUBDIR, 1'b0);
    shaped_entry(FIRST_UNUSED, 8'h42, ATTR_SUBDIR, 1'b0);
    // listed kinds: plain file, subdirectory by bit, dot entry, parent links
    shaped_entry(8'h41, 8'h42, 8'h20, 1'b0);
    shaped_entry(8'h41, 8'h42, ATTR_SUBDIR, 1'b0);
    shaped_entry(DOT_CHAR, 8'h20, 8'h00, 1'b0);
    shaped_entry(DOT_CHAR, DOT_CHAR, ATTR_SUBDIR, 1'b0);
    shaped_entry(8'h41, DOT_CHAR, ATTR_SUBDIR, 1'b0);
    // realign in the middle of an entry: partial bytes dropped, counts restart
    randomise_entry();
    for (int i = 0; i < 13; i++)
      send_byte(ent[i], 1'b0);
    shaped_entry(8'h41, 8'h42, 8'h20, 1'b1);
    // each stamp selection on a listed file, spare code included
    write_stamp_select(SEL_CREATED);
    shaped_entry(8'h41, 8'h42, 8'h20, 1'b0);
    write_stamp_select(SEL_ACCESSED);
    shaped_entry(8'h41, 8'h42, 8'h20, 1'b0);
    write_stamp_select(SEL_SPARE);
    shaped_entry(8'h41, 8'h42, 8'h20, 1'b0);

    // ---- random: sender 26/receiver 72, then swapped, then no idling ----
    random_phase(SEL_CREATED, 26, 72);
    random_phase(SEL_ACCESSED, 72, 26);
    random_phase(SEL_SPARE, 0, 0);

    settle();
    $display("Covered %0d input beats, %0d entries checked: all entry kinds, every stamp",
             bytes_sent, entries_seen);
    $display("selection, mid-entry realigns and stalls on both sides.");
    if (mismatches == 0 && awaited == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/fdep_pkg.sv
sv/fdep_front.sv
sv/fdep_fifo.sv
sv/fdep_back.sv
sv/fat_directory_entry_parser.sv
sv/fdep_checker.sv
tb/fdep_entry_checker.sv
tb/tb.sv
